FILE: hw/rtl/spsc_pkg.sv
`timescale 1ns / 1ps

package spsc_pkg;

   // Opcodes carried on req_tuser
   localparam logic [1:0] OP_TICK        = 2'd0;
   localparam logic [1:0] OP_ARM         = 2'd1;
   localparam logic [1:0] OP_GRIP_PRESET = 2'd2;
   localparam logic [1:0] OP_GRIP_PULSE  = 2'd3;

   // Grip preset codes
   localparam logic [1:0] GRIP_CODE_OPEN   = 2'd0;
   localparam logic [1:0] GRIP_CODE_CLOSED = 2'd1;

   // Configuration register indexes
   localparam logic [1:0] REG_ARM_INTERVAL_A = 2'd0;
   localparam logic [1:0] REG_ARM_INTERVAL_B = 2'd1;
   localparam logic [1:0] REG_ARM_INTERVAL_C = 2'd2;
   localparam logic [1:0] REG_GRIP_INTERVAL  = 2'd3;

   localparam int PULSE_BITS_DEFAULT = 12;
   localparam int PULSE_OUT_BITS     = 12;
   localparam int INTERVAL_BITS      = 16;
   localparam int ANGLE_BITS         = 9;
   localparam int ANGLE_X_BITS       = 11;   // signed angle after offset, -8..513

   localparam int unsigned PULSE_RESET    = 1500;
   localparam int unsigned GRIP_CLOSED    = 880;
   localparam int unsigned GRIP_OPEN      = 2000;
   localparam int unsigned MAP_CENTER     = 500;
   localparam int unsigned MAP_SCALE      = 20;     // 2000/300 reduced to 20/3
   localparam int unsigned ANGLE_A_OFFSET = 8;
   localparam int unsigned ANGLE_B_OFFSET = 2;

   // floor(n/3) == (n * 43691) >> 17 for every n below 2^16
   localparam int unsigned DIV3_RECIP = 43691;
   localparam int          DIV3_SHIFT = 17;

   localparam int NUM_CHANNELS = 4;
   localparam int CH_GRIP      = 3;

endpackage

FILE: hw/rtl/spsc_angle_map.sv
`timescale 1ns / 1ps

// Angle in degrees to pulse width: x*20/3 truncated toward zero, plus center.
module spsc_angle_map
   import spsc_pkg::*;
#(
   parameter int PULSE_BITS = PULSE_BITS_DEFAULT
) (
   input  logic signed [ANGLE_X_BITS-1:0] angle,
   output logic        [PULSE_BITS-1:0]   pulse
);

   localparam int MAG_BITS  = ANGLE_X_BITS - 1;
   localparam int PROD_BITS = 31;

   logic                 neg;
   logic [MAG_BITS-1:0]  mag;
   logic [13:0]          scaled;
   logic [PROD_BITS-1:0] prod;
   logic [11:0]          quot;
   logic [12:0]          sum;

   always_comb begin
      neg    = angle[ANGLE_X_BITS-1];
      mag    = neg ? MAG_BITS'(-angle) : MAG_BITS'(angle);
      scaled = 14'(mag * 14'(MAP_SCALE));
      prod   = PROD_BITS'(scaled) * PROD_BITS'(DIV3_RECIP);
      quot   = prod[DIV3_SHIFT +: 12];
      sum    = neg ? (13'(MAP_CENTER) - 13'(quot)) : (13'(MAP_CENTER) + 13'(quot));
      pulse  = PULSE_BITS'(sum[11:0]);
   end

endmodule

FILE: hw/rtl/spsc_slew_step.sv
`timescale 1ns / 1ps

// One unit step of a channel toward its target when step is set.
module spsc_slew_step
   import spsc_pkg::*;
#(
   parameter int PULSE_BITS = PULSE_BITS_DEFAULT
) (
   input  logic                  step,
   input  logic [PULSE_BITS-1:0] cur,
   input  logic [PULSE_BITS-1:0] tgt,
   output logic [PULSE_BITS-1:0] nxt
);

   always_comb begin
      nxt = cur;
      if (step) begin
         if (tgt > cur) begin
            nxt = PULSE_BITS'(cur + PULSE_BITS'(1));
         end else if (tgt < cur) begin
            nxt = PULSE_BITS'(cur - PULSE_BITS'(1));
         end
      end
   end

endmodule

FILE: hw/rtl/servo_pulse_slew_controller_top.sv
// Four-channel servo pulse slew controller (arm a/b/c, grip d).
// rsp_tvalid rises after a req transfer passes the input register, then the result register.
// Throughput: one item per cycle unless rsp_tready stalls; one compare-and-step state update.
// Reset (synchronous, active high): pulses and targets 1500, tick counters zero,
// all intervals 1000, both channel registers empty.
`timescale 1ns / 1ps

module servo_pulse_slew_controller_top
   import spsc_pkg::*;
#(
   parameter int PULSE_BITS = PULSE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [1:0] opcode
   input  logic [1:0]               req_tuser,
   // [8:0] angle_a, [17:9] angle_b, [26:18] angle_c, [28:27] grip_code,
   // [40:29] grip_pulse, [47:41] zero
   input  logic [47:0]              req_tdata,

   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [11:0] pulse_a, [23:12] pulse_b, [35:24] pulse_c, [47:36] pulse_d,
   // [48] arm_moving, [49] grip_moving, [55:50] zero
   output logic [55:0]              rsp_tdata,

   input  logic                     csr_we,
   input  logic [1:0]               csr_addr,
   input  logic [INTERVAL_BITS-1:0] csr_wdata
);

   localparam int ARM_CNT_BITS = INTERVAL_BITS + 2;   // holds the sum of three intervals

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [INTERVAL_BITS-1:0] ivl_a_ff, ivl_b_ff, ivl_c_ff, ivl_g_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ivl_a_ff <= INTERVAL_BITS'(1000);
         ivl_b_ff <= INTERVAL_BITS'(1000);
         ivl_c_ff <= INTERVAL_BITS'(1000);
         ivl_g_ff <= INTERVAL_BITS'(1000);
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_ARM_INTERVAL_A: ivl_a_ff <= csr_wdata;
            REG_ARM_INTERVAL_B: ivl_b_ff <= csr_wdata;
            REG_ARM_INTERVAL_C: ivl_c_ff <= csr_wdata;
            REG_GRIP_INTERVAL:  ivl_g_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Input register. It drains whenever the result register can take the
   // item, so a new transfer lands every cycle under steady flow.
   // ---------------------------------------------------------------------
   logic                  in_vld_ff, in_vld_in;
   logic [1:0]            in_op_ff;
   logic [ANGLE_BITS-1:0] in_ang_a_ff, in_ang_b_ff, in_ang_c_ff;
   logic [1:0]            in_gcode_ff;
   logic [11:0]           in_gpulse_ff;

   logic rsp_vld_ff, rsp_vld_in;
   logic req_fire;
   logic item_go;      // input register item is processed this cycle

   assign item_go    = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || item_go;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_fire) begin
         in_vld_in = 1'b1;
      end else if (item_go) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff     <= req_tuser;
         in_ang_a_ff  <= req_tdata[8:0];
         in_ang_b_ff  <= req_tdata[17:9];
         in_ang_c_ff  <= req_tdata[26:18];
         in_gcode_ff  <= req_tdata[28:27];
         in_gpulse_ff <= req_tdata[40:29];
      end
   end

   // ---------------------------------------------------------------------
   // Channel state
   // ---------------------------------------------------------------------
   logic [NUM_CHANNELS-1:0][PULSE_BITS-1:0] cur_ff, cur_in, cur_step;
   logic [NUM_CHANNELS-1:0][PULSE_BITS-1:0] tgt_ff, tgt_in;
   logic [ARM_CNT_BITS-1:0]                 arm_cnt_ff, arm_cnt_in;
   logic [INTERVAL_BITS-1:0]                grip_cnt_ff, grip_cnt_in;

   logic                     arm_busy, grip_busy;
   logic                     is_tick, arm_step, grip_step;
   logic [ARM_CNT_BITS-1:0]  arm_period;
   logic [ARM_CNT_BITS:0]    arm_cnt_inc;
   logic [INTERVAL_BITS:0]   grip_cnt_inc;

   assign arm_busy  = (cur_ff[0] != tgt_ff[0]) || (cur_ff[1] != tgt_ff[1]) ||
                      (cur_ff[2] != tgt_ff[2]);
   assign grip_busy = cur_ff[CH_GRIP] != tgt_ff[CH_GRIP];

   assign arm_period   = ARM_CNT_BITS'(ivl_a_ff) + ARM_CNT_BITS'(ivl_b_ff) +
                         ARM_CNT_BITS'(ivl_c_ff);
   assign arm_cnt_inc  = (ARM_CNT_BITS+1)'(arm_cnt_ff) + (ARM_CNT_BITS+1)'(1);
   assign grip_cnt_inc = (INTERVAL_BITS+1)'(grip_cnt_ff) + (INTERVAL_BITS+1)'(1);

   // a step is taken on the first tick of a count period
   assign is_tick   = in_op_ff == OP_TICK;
   assign arm_step  = is_tick && arm_busy  && (arm_cnt_ff  == '0);
   assign grip_step = is_tick && grip_busy && (grip_cnt_ff == '0);

   for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_slew
      spsc_slew_step #(
         .PULSE_BITS (PULSE_BITS)
      ) u_slew (
         .step (ch == CH_GRIP ? grip_step : arm_step),
         .cur  (cur_ff[ch]),
         .tgt  (tgt_ff[ch]),
         .nxt  (cur_step[ch])
      );
   end

   // Arm targets: a is offset down by 8 degrees, b up by 2.
   logic signed [ANGLE_X_BITS-1:0] ang_x_a, ang_x_b, ang_x_c;
   logic [PULSE_BITS-1:0]          map_a, map_b, map_c;

   assign ang_x_a = ANGLE_X_BITS'(in_ang_a_ff) - ANGLE_X_BITS'(ANGLE_A_OFFSET);
   assign ang_x_b = ANGLE_X_BITS'(in_ang_b_ff) + ANGLE_X_BITS'(ANGLE_B_OFFSET);
   assign ang_x_c = ANGLE_X_BITS'(in_ang_c_ff);

   spsc_angle_map #(.PULSE_BITS(PULSE_BITS)) u_map_a (.angle(ang_x_a), .pulse(map_a));
   spsc_angle_map #(.PULSE_BITS(PULSE_BITS)) u_map_b (.angle(ang_x_b), .pulse(map_b));
   spsc_angle_map #(.PULSE_BITS(PULSE_BITS)) u_map_c (.angle(ang_x_c), .pulse(map_c));

   always_comb begin
      cur_in      = cur_ff;
      tgt_in      = tgt_ff;
      arm_cnt_in  = arm_cnt_ff;
      grip_cnt_in = grip_cnt_ff;
      if (item_go) begin
         case (in_op_ff)
            OP_TICK: begin
               cur_in = cur_step;
               // idle group parks its counter at zero; a count past a shrunk
               // period wraps here too
               if (!arm_busy) begin
                  arm_cnt_in = '0;
               end else if (arm_cnt_inc >= (ARM_CNT_BITS+1)'(arm_period)) begin
                  arm_cnt_in = '0;
               end else begin
                  arm_cnt_in = arm_cnt_inc[ARM_CNT_BITS-1:0];
               end
               if (!grip_busy) begin
                  grip_cnt_in = '0;
               end else if (grip_cnt_inc >= (INTERVAL_BITS+1)'(ivl_g_ff)) begin
                  grip_cnt_in = '0;
               end else begin
                  grip_cnt_in = grip_cnt_inc[INTERVAL_BITS-1:0];
               end
            end
            OP_ARM: begin
               tgt_in[0]  = map_a;
               tgt_in[1]  = map_b;
               tgt_in[2]  = map_c;
               arm_cnt_in = '0;
            end
            OP_GRIP_PRESET: begin
               // codes other than open and closed keep the target but restart timing
               if (in_gcode_ff == GRIP_CODE_CLOSED) begin
                  tgt_in[CH_GRIP] = PULSE_BITS'(GRIP_CLOSED);
               end else if (in_gcode_ff == GRIP_CODE_OPEN) begin
                  tgt_in[CH_GRIP] = PULSE_BITS'(GRIP_OPEN);
               end
               grip_cnt_in = '0;
            end
            default: begin   // OP_GRIP_PULSE
               tgt_in[CH_GRIP] = PULSE_BITS'(in_gpulse_ff);
               grip_cnt_in     = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            cur_ff[ch] <= PULSE_BITS'(PULSE_RESET);
            tgt_ff[ch] <= PULSE_BITS'(PULSE_RESET);
         end
         arm_cnt_ff  <= '0;
         grip_cnt_ff <= '0;
      end else begin
         cur_ff      <= cur_in;
         tgt_ff      <= tgt_in;
         arm_cnt_ff  <= arm_cnt_in;
         grip_cnt_ff <= grip_cnt_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register: holds the post-update snapshot until transferred.
   // ---------------------------------------------------------------------
   logic [NUM_CHANNELS-1:0][PULSE_OUT_BITS-1:0] rsp_pulse_ff;
   logic                                        rsp_arm_mv_ff, rsp_grip_mv_ff;

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (item_go) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_go) begin
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            rsp_pulse_ff[ch] <= cur_in[ch][PULSE_OUT_BITS-1:0];
         end
         rsp_arm_mv_ff  <= (cur_in[0] != tgt_in[0]) || (cur_in[1] != tgt_in[1]) ||
                           (cur_in[2] != tgt_in[2]);
         rsp_grip_mv_ff <= cur_in[CH_GRIP] != tgt_in[CH_GRIP];
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'd0, rsp_grip_mv_ff, rsp_arm_mv_ff,
                        rsp_pulse_ff[3], rsp_pulse_ff[2], rsp_pulse_ff[1], rsp_pulse_ff[0]};

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // channel state only moves when an item is processed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !item_go |=> $stable(cur_ff) && $stable(tgt_ff) && $stable(arm_cnt_ff) &&
                   $stable(grip_cnt_ff))
      else $error("channel state changed without a processed item");

   // an arm command restarts the arm step timing
   a_arm_cmd_clears: assert property (@(posedge clock) disable iff (reset)
      item_go && (in_op_ff == OP_ARM) |=> arm_cnt_ff == '0)
      else $error("arm counter not cleared by arm command");

   // an idle arm group keeps its counter parked
   a_arm_idle_zero: assert property (@(posedge clock) disable iff (reset)
      item_go && is_tick && !arm_busy |=> arm_cnt_ff == '0)
      else $error("arm counter ran while arm group idle");

   // the result register never drops an unaccepted result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      item_go |-> !rsp_vld_ff || rsp_tready)
      else $error("result register overwritten while stalled");

endmodule

FILE: verif/servo_pulse_slew_controller_top_tb.sv
`timescale 1ns / 1ps

module servo_pulse_slew_controller_top_tb;
   import spsc_pkg::*;

   // grip preset codes that leave the grip target alone
   localparam logic [1:0] GRIP_CODE_HOLD_2 = 2'd2;
   localparam logic [1:0] GRIP_CODE_HOLD_3 = 2'd3;

   localparam int QUIET_LIMIT  = 5000;   // cycles with no transfer on either side
   localparam int PHASE_ITEMS  = 125;
   localparam int PRINT_LIMIT  = 50;

   // one response: four pulse widths plus the two busy flags
   typedef struct packed {
      logic [11:0] width_a;
      logic [11:0] width_b;
      logic [11:0] width_c;
      logic [11:0] width_d;
      logic        arm_moving;
      logic        grip_moving;
   } servo_snapshot_type;

   // one row of the directed table; fixed marks a hand-written expectation
   typedef struct packed {
      logic [1:0]         op;
      logic [8:0]         ang_a;
      logic [8:0]         ang_b;
      logic [8:0]         ang_c;
      logic [1:0]         gcode;
      logic [11:0]        gpulse;
      logic               fixed;
      servo_snapshot_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [1:0] opcode
   logic [1:0]  req_tuser = OP_TICK;
   // [8:0] angle_a, [17:9] angle_b, [26:18] angle_c, [28:27] grip_code,
   // [40:29] grip_pulse, [47:41] zero
   logic [47:0] req_tdata = '0;

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [11:0] pulse_a, [23:12] pulse_b, [35:24] pulse_c, [47:36] pulse_d,
   // [48] arm_moving, [49] grip_moving, [55:50] zero
   logic [55:0] rsp_tdata;

   logic                     csr_we = 1'b0;
   logic [1:0]               csr_addr = REG_ARM_INTERVAL_A;
   logic [INTERVAL_BITS-1:0] csr_wdata = '0;

   servo_pulse_slew_controller_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Slew predictor state: its own copy of the pulses, targets, tick
   // counters and interval registers, all at reset values.
   // ------------------------------------------------------------------
   logic [11:0] now_width[4]  = '{12'd1500, 12'd1500, 12'd1500, 12'd1500};
   logic [11:0] goal_width[4] = '{12'd1500, 12'd1500, 12'd1500, 12'd1500};
   int unsigned arm_ticks  = 0;
   int unsigned grip_ticks = 0;
   int unsigned ivl_a = 1000, ivl_b = 1000, ivl_c = 1000, ivl_grip = 1000;

   servo_snapshot_type expected_pulses[$];
   stim_row_type       directed_rows[$];

   // bookkeeping
   int  mismatches        = 0;
   int  requests_sent     = 0;
   int  responses_checked = 0;
   int  interval_sets     = 0;
   int  arm_settles       = 0;
   int  grip_settles      = 0;
   int  quiet_cycles      = 0;
   int  stall_left        = 0;
   bit  gaps_on           = 1'b1;
   bit  stalls_on         = 1'b1;

   // angle in degrees (already offset) to pulse width; SV int division
   // truncates toward zero, which is what negative angles need
   function automatic logic [11:0] degrees_to_width(input int deg);
      int p;
      p = deg * 2000 / 300 + 500;
      return p[11:0];
   endfunction

   function automatic void step_channel(input int ch);
      if (goal_width[ch] > now_width[ch])
         now_width[ch] = now_width[ch] + 12'd1;
      else if (goal_width[ch] < now_width[ch])
         now_width[ch] = now_width[ch] - 12'd1;
   endfunction

   function automatic bit arm_off_target();
      return now_width[0] != goal_width[0] || now_width[1] != goal_width[1] ||
             now_width[2] != goal_width[2];
   endfunction

   function automatic bit grip_off_target();
      return now_width[3] != goal_width[3];
   endfunction

   // Advance the predictor by one accepted request and return the response
   // it should produce (state after the update).
   function automatic servo_snapshot_type predict_servo(
      input logic [1:0] op, input logic [8:0] ang_a, input logic [8:0] ang_b,
      input logic [8:0] ang_c, input logic [1:0] gcode, input logic [11:0] gpulse);
      int unsigned period;
      bit arm_was, grip_was;
      servo_snapshot_type snap;
      period   = ivl_a + ivl_b + ivl_c;
      arm_was  = arm_off_target();
      grip_was = grip_off_target();
      case (op)
         OP_TICK: begin
            // arm group: step on count zero, count wraps at the period
            if (arm_was) begin
               if (arm_ticks == 0) begin
                  step_channel(0);
                  step_channel(1);
                  step_channel(2);
               end
               arm_ticks = (arm_ticks + 1 >= period) ? 0 : arm_ticks + 1;
            end else begin
               arm_ticks = 0;
            end
            if (grip_was) begin
               if (grip_ticks == 0)
                  step_channel(3);
               grip_ticks = (grip_ticks + 1 >= ivl_grip) ? 0 : grip_ticks + 1;
            end else begin
               grip_ticks = 0;
            end
            if (arm_was && !arm_off_target())
               arm_settles++;
            if (grip_was && !grip_off_target())
               grip_settles++;
         end
         OP_ARM: begin
            goal_width[0] = degrees_to_width(int'(ang_a) - 8);
            goal_width[1] = degrees_to_width(int'(ang_b) + 2);
            goal_width[2] = degrees_to_width(int'(ang_c));
            arm_ticks = 0;
         end
         OP_GRIP_PRESET: begin
            if (gcode == GRIP_CODE_CLOSED)
               goal_width[3] = 12'(GRIP_CLOSED);
            else if (gcode == GRIP_CODE_OPEN)
               goal_width[3] = 12'(GRIP_OPEN);
            grip_ticks = 0;
         end
         default: begin
            goal_width[3] = gpulse;
            grip_ticks = 0;
         end
      endcase
      snap.width_a     = now_width[0];
      snap.width_b     = now_width[1];
      snap.width_c     = now_width[2];
      snap.width_d     = now_width[3];
      snap.arm_moving  = arm_off_target();
      snap.grip_moving = grip_off_target();
      return snap;
   endfunction

   function automatic servo_snapshot_type snap_of(
      input int wa, input int wb, input int wc, input int wd, input int am, input int gm);
      servo_snapshot_type s;
      s.width_a = wa[11:0];
      s.width_b = wb[11:0];
      s.width_c = wc[11:0];
      s.width_d = wd[11:0];
      s.arm_moving  = am[0];
      s.grip_moving = gm[0];
      return s;
   endfunction

   // mostly no gap, some short ones, a few long ones
   function automatic int idle_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // angle that lands close to a given width once the channel offset is added
   function automatic logic [8:0] angle_near(input logic [11:0] width, input int offset);
      int deg;
      deg = (int'(width) - 500) * 3 / 20 + offset + int'($urandom_range(0, 8)) - 4;
      if (deg < 0)
         deg = 0;
      if (deg > 511)
         deg = 511;
      return deg[8:0];
   endfunction

   task automatic add_row(
      input logic [1:0] op, input logic [8:0] ang_a, input logic [8:0] ang_b,
      input logic [8:0] ang_c, input logic [1:0] gcode, input logic [11:0] gpulse,
      input bit fixed, input servo_snapshot_type want);
      stim_row_type r;
      r.op = op; r.ang_a = ang_a; r.ang_b = ang_b; r.ang_c = ang_c;
      r.gcode = gcode; r.gpulse = gpulse; r.fixed = fixed; r.want = want;
      directed_rows.push_back(r);
   endtask

   task automatic flag_mismatch(input string field, input logic [63:0] got,
                                input logic [63:0] want);
      if (mismatches < PRINT_LIMIT)
         $display("%0t mismatch on %s at response %0d: got %0d expected %0d",
                  $realtime, field, responses_checked, got, want);
      mismatches++;
   endtask

   // ------------------------------------------------------------------
   // Request side: present one item, hold until the transfer, then
   // predict and maybe leave a gap. tvalid stays high across back-to-back
   // items so it never gets two assignments in one step.
   // ------------------------------------------------------------------
   task automatic send_request(
      input logic [1:0] op, input logic [8:0] ang_a, input logic [8:0] ang_b,
      input logic [8:0] ang_c, input logic [1:0] gcode, input logic [11:0] gpulse,
      input bit fixed, input servo_snapshot_type want);
      servo_snapshot_type predicted;
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, gpulse, gcode, ang_c, ang_b, ang_a};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      // predictor always runs so its state tracks the block; a typed row
      // overrides only what gets compared
      predicted = predict_servo(op, ang_a, ang_b, ang_c, gcode, gpulse);
      expected_pulses.push_back(fixed ? want : predicted);
      requests_sent++;
      gap = gaps_on ? idle_length() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender holds off until every outstanding response has come back
   task automatic settle_outputs();
      req_tvalid <= 1'b0;
      while (expected_pulses.size() != 0)
         @(posedge clock);
   endtask

   // all four interval registers, one write per cycle; block is idle here
   task automatic load_intervals(input int unsigned ia, input int unsigned ib,
                                 input int unsigned ic, input int unsigned ig);
      csr_we    <= 1'b1;
      csr_addr  <= REG_ARM_INTERVAL_A;
      csr_wdata <= ia[15:0];
      @(posedge clock);
      csr_addr  <= REG_ARM_INTERVAL_B;
      csr_wdata <= ib[15:0];
      @(posedge clock);
      csr_addr  <= REG_ARM_INTERVAL_C;
      csr_wdata <= ic[15:0];
      @(posedge clock);
      csr_addr  <= REG_GRIP_INTERVAL;
      csr_wdata <= ig[15:0];
      @(posedge clock);
      csr_we <= 1'b0;
      ivl_a = ia;
      ivl_b = ib;
      ivl_c = ic;
      ivl_grip = ig;
      interval_sets++;
   endtask

   // Random traffic: mostly ticks so channels actually slew, commands that
   // aim near the current position so groups reach target and go idle,
   // plus far-off commands and presets as noise. Unused fields stay random.
   task automatic random_request();
      int unsigned roll;
      int wd;
      logic [1:0]  op;
      logic [8:0]  a, b, c;
      logic [1:0]  gc;
      logic [11:0] gp;
      roll = $urandom_range(0, 99);
      a  = 9'($urandom_range(0, 511));
      b  = 9'($urandom_range(0, 511));
      c  = 9'($urandom_range(0, 511));
      gc = 2'($urandom_range(0, 3));
      gp = 12'($urandom_range(0, 4095));
      if (roll < 70) begin
         op = OP_TICK;
      end else if (roll < 80) begin
         op = OP_ARM;
         a = angle_near(now_width[0], 8);
         b = angle_near(now_width[1], -2);
         c = angle_near(now_width[2], 0);
      end else if (roll < 84) begin
         op = OP_ARM;
      end else if (roll < 93) begin
         op = OP_GRIP_PULSE;
         wd = int'(now_width[3]) + int'($urandom_range(0, 60)) - 30;
         if (wd < 0)
            wd = 0;
         if (wd > 4095)
            wd = 4095;
         gp = wd[11:0];
      end else if (roll < 95) begin
         op = OP_GRIP_PULSE;
      end else begin
         op = OP_GRIP_PRESET;
      end
      send_request(op, a, b, c, gc, gp, 1'b0, '0);
   endtask

   // field-by-field compare of one response against the oldest expectation
   task automatic check_response(input logic [55:0] d);
      servo_snapshot_type want;
      if (expected_pulses.size() == 0) begin
         flag_mismatch("unexpected response", 64'(d), 64'(0));
         return;
      end
      want = expected_pulses.pop_front();
      if (d[11:0] !== want.width_a)
         flag_mismatch("pulse_a", 64'(d[11:0]), 64'(want.width_a));
      if (d[23:12] !== want.width_b)
         flag_mismatch("pulse_b", 64'(d[23:12]), 64'(want.width_b));
      if (d[35:24] !== want.width_c)
         flag_mismatch("pulse_c", 64'(d[35:24]), 64'(want.width_c));
      if (d[47:36] !== want.width_d)
         flag_mismatch("pulse_d", 64'(d[47:36]), 64'(want.width_d));
      if (d[48] !== want.arm_moving)
         flag_mismatch("arm_moving", 64'(d[48]), 64'(want.arm_moving));
      if (d[49] !== want.grip_moving)
         flag_mismatch("grip_moving", 64'(d[49]), 64'(want.grip_moving));
      responses_checked++;
   endtask

   // ------------------------------------------------------------------
   // Response side: check transfers, random backpressure, and count
   // cycles with no transfer anywhere for the watchdog.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
         stall_left   = 0;
         rsp_tready  <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_response(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (stall_left != 0)
            stall_left = stall_left - 1;
         else if (stalls_on)
            stall_left = idle_length();
         rsp_tready <= (stall_left == 0);
      end
   end

   // watchdog: a lost response or a hung handshake stops everything
   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
               QUIET_LIMIT, expected_pulses.size());
      $display("** servo_pulse_slew_controller_top: FAILED **");
      $finish;
   end

   // interval settings per random phase: {a, b, c, grip}. A long period
   // followed by short ones makes the counters wrap on a register change
   // while moving; zero and one periods step on every tick; the last
   // phase is drawn at random.
   int unsigned phase_ivl[6][4] = '{
      '{3, 4, 5, 9},
      '{0, 0, 0, 0},
      '{1, 0, 0, 1},
      '{65535, 65535, 65535, 65535},
      '{0, 2, 1, 3},
      '{0, 0, 0, 0}
   };

   initial begin : stimulus
      int p;
      int n;

      // ---- directed table; reset intervals (arm period 3000, grip 1000)
      // parked at reset: every channel at 1500, nothing moving
      add_row(OP_TICK, 9'd0, 9'd0, 9'd0, GRIP_CODE_OPEN, 12'd0,
              1'b1, snap_of(1500, 1500, 1500, 1500, 0, 0));
      // grip presets: closed, open, then the two codes that keep the target
      add_row(OP_GRIP_PRESET, 9'd0, 9'd0, 9'd0, GRIP_CODE_CLOSED, 12'd0,
              1'b1, snap_of(1500, 1500, 1500, 1500, 0, 1));
      add_row(OP_GRIP_PRESET, 9'h1FF, 9'h1FF, 9'h1FF, GRIP_CODE_OPEN, 12'hFFF,
              1'b1, snap_of(1500, 1500, 1500, 1500, 0, 1));
      add_row(OP_GRIP_PRESET, 9'd0, 9'd0, 9'd0, GRIP_CODE_HOLD_2, 12'd0,
              1'b1, snap_of(1500, 1500, 1500, 1500, 0, 1));
      add_row(OP_GRIP_PRESET, 9'h1FF, 9'h1FF, 9'h1FF, GRIP_CODE_HOLD_3, 12'hFFF,
              1'b1, snap_of(1500, 1500, 1500, 1500, 0, 1));
      // grip target back onto the current width: idle again
      add_row(OP_GRIP_PULSE, 9'd0, 9'd0, 9'd0, GRIP_CODE_OPEN, 12'd1500,
              1'b1, snap_of(1500, 1500, 1500, 1500, 0, 0));
      // arm angles that map exactly onto 1500 after the channel offsets
      add_row(OP_ARM, 9'd158, 9'd148, 9'd150, GRIP_CODE_OPEN, 12'd0,
              1'b1, snap_of(1500, 1500, 1500, 1500, 0, 0));
      add_row(OP_TICK, 9'd0, 9'd0, 9'd0, GRIP_CODE_OPEN, 12'd0,
              1'b1, snap_of(1500, 1500, 1500, 1500, 0, 0));
      // zero angles: channel a goes below zero before mapping
      add_row(OP_ARM, 9'd0, 9'd0, 9'd0, GRIP_CODE_OPEN, 12'd0,
              1'b1, snap_of(1500, 1500, 1500, 1500, 1, 0));
      // first tick after a command steps at once, the next one waits
      add_row(OP_TICK, 9'd0, 9'd0, 9'd0, GRIP_CODE_OPEN, 12'd0,
              1'b1, snap_of(1499, 1499, 1499, 1500, 1, 0));
      add_row(OP_TICK, 9'd0, 9'd0, 9'd0, GRIP_CODE_OPEN, 12'd0,
              1'b1, snap_of(1499, 1499, 1499, 1500, 1, 0));
      // widest grip pulse, unused fields all ones
      add_row(OP_GRIP_PULSE, 9'h1FF, 9'h1FF, 9'h1FF, GRIP_CODE_HOLD_3, 12'hFFF,
              1'b1, snap_of(1499, 1499, 1499, 1500, 1, 1));
      add_row(OP_TICK, 9'h1FF, 9'h1FF, 9'h1FF, GRIP_CODE_HOLD_3, 12'hFFF, 1'b0, '0);
      add_row(OP_GRIP_PULSE, 9'd0, 9'd0, 9'd0, GRIP_CODE_OPEN, 12'd0, 1'b0, '0);
      add_row(OP_TICK, 9'd0, 9'd0, 9'd0, GRIP_CODE_OPEN, 12'd0, 1'b0, '0);
      // largest angles the field can carry, well past 300
      add_row(OP_ARM, 9'h1FF, 9'h1FF, 9'h1FF, GRIP_CODE_HOLD_3, 12'hFFF, 1'b0, '0);
      add_row(OP_TICK, 9'd0, 9'd0, 9'd0, GRIP_CODE_OPEN, 12'd0, 1'b0, '0);
      add_row(OP_TICK, 9'd0, 9'd0, 9'd0, GRIP_CODE_OPEN, 12'd0, 1'b0, '0);
      add_row(OP_ARM, 9'd300, 9'd300, 9'd300, GRIP_CODE_CLOSED, 12'h800, 1'b0, '0);
      add_row(OP_TICK, 9'd0, 9'd0, 9'd0, GRIP_CODE_OPEN, 12'd0, 1'b0, '0);
      // channel a just under its offset, c just over the nominal range
      add_row(OP_ARM, 9'd7, 9'd0, 9'd301, GRIP_CODE_OPEN, 12'd0, 1'b0, '0);
      add_row(OP_TICK, 9'd0, 9'd0, 9'd0, GRIP_CODE_OPEN, 12'd0, 1'b0, '0);
      add_row(OP_GRIP_PRESET, 9'd0, 9'd0, 9'd0, GRIP_CODE_CLOSED, 12'd0, 1'b0, '0);
      add_row(OP_TICK, 9'd0, 9'd0, 9'd0, GRIP_CODE_OPEN, 12'd0, 1'b0, '0);
      add_row(OP_TICK, 9'd0, 9'd0, 9'd0, GRIP_CODE_OPEN, 12'd0, 1'b0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].ang_a,
                      directed_rows[i].ang_b, directed_rows[i].ang_c,
                      directed_rows[i].gcode, directed_rows[i].gpulse,
                      directed_rows[i].fixed, directed_rows[i].want);

      // ---- random phases, intervals rewritten only once drained
      for (p = 0; p < 6; p++) begin
         settle_outputs();
         if (p == 5) begin
            phase_ivl[5][0] = $urandom_range(0, 6);
            phase_ivl[5][1] = $urandom_range(0, 6);
            phase_ivl[5][2] = $urandom_range(0, 6);
            phase_ivl[5][3] = $urandom_range(0, 8);
         end
         load_intervals(phase_ivl[p][0], phase_ivl[p][1], phase_ivl[p][2],
                        phase_ivl[p][3]);
         // two phases run with no gaps and no backpressure at all
         gaps_on   = (p != 1 && p != 4);
         stalls_on = (p != 1 && p != 4);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // mid-phase hold-off until everything has drained
            if (n == PHASE_ITEMS / 2)
               settle_outputs();
            random_request();
         end
      end

      settle_outputs();
      repeat (6) @(posedge clock);

      $display("covered %0d requests and %0d checked responses over %0d interval settings",
               requests_sent, responses_checked, interval_sets);
      $display("arm group reached target %0d times, grip %0d times; %0d mismatches",
               arm_settles, grip_settles, mismatches);
      if (mismatches == 0)
         $display("** servo_pulse_slew_controller_top: PASSED **");
      else
         $display("** servo_pulse_slew_controller_top: FAILED **");
      $finish;
   end

endmodule
